// ----- hw/rtl/vbmmio_pkg.sv -----
// Shared types, offsets and constants of the balloon virtio-mmio register block.
package vbmmio_pkg;

  // Stream widths
  localparam int IN_TDATA_W  = 112;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W   = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_GOAL       = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETARGET_PERIOD = 1'd1;

  localparam logic [31:0] PAGE_GOAL_RST       = 32'd1024;
  localparam logic [31:0] RETARGET_PERIOD_RST = 32'h0800_0000;

  // Access kinds
  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // Register offsets
  localparam logic [8:0] OFF_MAGIC       = 9'h000;
  localparam logic [8:0] OFF_VERSION     = 9'h004;
  localparam logic [8:0] OFF_DEVICE_ID   = 9'h008;
  localparam logic [8:0] OFF_VENDOR_ID   = 9'h00C;
  localparam logic [8:0] OFF_DEV_FEAT    = 9'h010;
  localparam logic [8:0] OFF_DEV_FEAT_SEL = 9'h014;
  localparam logic [8:0] OFF_QUEUE_SEL   = 9'h030;
  localparam logic [8:0] OFF_QUEUE_NUM_MAX = 9'h034;
  localparam logic [8:0] OFF_QUEUE_READY = 9'h044;
  localparam logic [8:0] OFF_QUEUE_NOTIFY = 9'h050;
  localparam logic [8:0] OFF_INT_STATUS  = 9'h060;
  localparam logic [8:0] OFF_INT_ACK     = 9'h064;
  localparam logic [8:0] OFF_STATUS      = 9'h070;
  localparam logic [8:0] OFF_CFG_GEN     = 9'h0FC;
  localparam logic [8:0] OFF_NUM_PAGES   = 9'h100;
  localparam logic [8:0] OFF_ACTUAL      = 9'h104;

  // Identity values
  localparam logic [31:0] ID_MAGIC   = 32'h7472_6976;
  localparam logic [31:0] ID_VERSION = 32'd2;
  localparam logic [31:0] ID_DEVICE  = 32'd5;
  localparam logic [31:0] ID_VENDOR  = 32'h494D_5246;
  localparam logic [31:0] QSIZE_MAX  = 32'd64;

  localparam int          STATUS_DRV_OK_BIT = 2;
  localparam logic [1:0]  IRQ_CONFIG        = 2'b10;

  typedef struct packed {
    logic        action;
    logic [8:0]  byte_offset;
    logic [31:0] write_data;
    logic [63:0] time_now;
  } item_t;

  // Packed so that read_data sits in the lowest bits
  typedef struct packed {
    logic        notify_queue;
    logic        notify_request;
    logic        config_irq_raised;
    logic [1:0]  interrupt_status;
    logic [31:0] read_data;
  } res_t;

  typedef struct packed {
    logic        fire;
    logic [63:0] deadline;
  } tmr_res_t;

endpackage

// ----- hw/rtl/vbmmio_timer.sv -----
// Retarget timer: deadline check and next deadline.
module vbmmio_timer (
  input  logic                    run,
  input  logic                    drv_ok,
  input  logic [63:0]             deadline,
  input  logic [63:0]             time_now,
  input  logic [31:0]             period,
  output vbmmio_pkg::tmr_res_t    tmr
);
  import vbmmio_pkg::*;

  logic passed;

  // zero deadline means none armed yet, so the first run flips
  assign passed       = (deadline == 64'd0) || (time_now >= deadline);
  assign tmr.fire     = run && drv_ok && passed;
  assign tmr.deadline = time_now + {32'd0, period};

endmodule

// ----- hw/rtl/vbmmio_regs.sv -----
// Device state registers, read/write decode and result forming.
module vbmmio_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  vbmmio_pkg::item_t   item,
  input  logic [31:0]         page_goal,
  input  logic [31:0]         retarget_period,
  output vbmmio_pkg::res_t    res
);
  import vbmmio_pkg::*;

  logic [31:0] device_status, device_status_next;
  logic [31:0] feature_select, feature_select_next;
  logic [1:0]  pending_interrupts, pending_interrupts_next;
  logic [31:0] selected_queue, selected_queue_next;
  logic [1:0]  queue_ready, queue_ready_next;
  logic [31:0] target_pages, target_pages_next;
  logic [31:0] reported_pages, reported_pages_next;
  logic [31:0] config_generation, config_generation_next;
  logic [63:0] retarget_deadline, retarget_deadline_next;

  // decode stage values, before the timer is applied
  logic [1:0]  pend_wr;
  logic [31:0] target_wr;
  logic [31:0] gen_wr;
  logic [63:0] deadline_wr;
  logic        tmr_run;
  logic        drv_ok;
  logic [31:0] rd;
  logic        nreq;
  logic        nq;
  tmr_res_t    tmr;

  always_comb begin
    device_status_next  = device_status;
    feature_select_next = feature_select;
    selected_queue_next = selected_queue;
    queue_ready_next    = queue_ready;
    reported_pages_next = reported_pages;
    pend_wr             = pending_interrupts;
    target_wr           = target_pages;
    gen_wr              = config_generation;
    deadline_wr         = retarget_deadline;
    tmr_run             = 1'b0;
    drv_ok              = device_status[STATUS_DRV_OK_BIT];
    rd                  = '0;
    nreq                = 1'b0;
    nq                  = 1'b0;
    if (item.action == ACT_READ) begin
      case (item.byte_offset)
        OFF_MAGIC:         rd = ID_MAGIC;
        OFF_VERSION:       rd = ID_VERSION;
        OFF_DEVICE_ID:     rd = ID_DEVICE;
        OFF_VENDOR_ID:     rd = ID_VENDOR;
        OFF_DEV_FEAT:      rd = {31'd0, feature_select == 32'd1};
        OFF_QUEUE_NUM_MAX: rd = (selected_queue < 32'd2) ? QSIZE_MAX : 32'd0;
        OFF_QUEUE_READY:   rd = {31'd0, queue_ready[selected_queue[0]]};
        OFF_INT_STATUS:    rd = {30'd0, pending_interrupts};
        OFF_STATUS:        rd = device_status;
        OFF_CFG_GEN:       rd = config_generation;
        OFF_NUM_PAGES:     rd = target_pages;
        OFF_ACTUAL:        rd = reported_pages;
        default:           rd = '0;
      endcase
    end else begin
      case (item.byte_offset)
        OFF_DEV_FEAT_SEL: feature_select_next = item.write_data;
        OFF_QUEUE_SEL:    selected_queue_next = item.write_data;
        OFF_QUEUE_READY:  queue_ready_next[selected_queue[0]] = item.write_data[0];
        OFF_QUEUE_NOTIFY: begin
          tmr_run = 1'b1;
          if (item.write_data <= 32'd1) begin
            nreq = 1'b1;
            nq   = item.write_data[0];
          end
        end
        OFF_INT_ACK: begin
          pend_wr = pending_interrupts & ~item.write_data[1:0];
          tmr_run = 1'b1;
        end
        OFF_ACTUAL:       reported_pages_next = item.write_data;
        OFF_STATUS: begin
          device_status_next = item.write_data;
          drv_ok             = item.write_data[STATUS_DRV_OK_BIT];
          if (item.write_data == 32'd0) begin
            // device reset; selectors are kept
            pend_wr             = '0;
            target_wr           = '0;
            reported_pages_next = '0;
            gen_wr              = '0;
            deadline_wr         = '0;
            queue_ready_next    = '0;
          end else begin
            tmr_run = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  vbmmio_timer u_timer (
    .run      (tmr_run),
    .drv_ok   (drv_ok),
    .deadline (retarget_deadline),
    .time_now (item.time_now),
    .period   (retarget_period),
    .tmr      (tmr)
  );

  always_comb begin
    pending_interrupts_next = pend_wr;
    target_pages_next       = target_wr;
    config_generation_next  = gen_wr;
    retarget_deadline_next  = deadline_wr;
    if (tmr.fire) begin
      pending_interrupts_next = pend_wr | IRQ_CONFIG;
      target_pages_next       = (target_pages == 32'd0) ? page_goal : 32'd0;
      config_generation_next  = config_generation + 32'd1;
      retarget_deadline_next  = tmr.deadline;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_status      <= '0;
      feature_select     <= '0;
      pending_interrupts <= '0;
      selected_queue     <= '0;
      queue_ready        <= '0;
      target_pages       <= '0;
      reported_pages     <= '0;
      config_generation  <= '0;
      retarget_deadline  <= '0;
    end else if (fire) begin
      device_status      <= device_status_next;
      feature_select     <= feature_select_next;
      pending_interrupts <= pending_interrupts_next;
      selected_queue     <= selected_queue_next;
      queue_ready        <= queue_ready_next;
      target_pages       <= target_pages_next;
      reported_pages     <= reported_pages_next;
      config_generation  <= config_generation_next;
      retarget_deadline  <= retarget_deadline_next;
    end
  end

  assign res.read_data         = rd;
  assign res.interrupt_status  = pending_interrupts_next;
  assign res.config_irq_raised = tmr.fire;
  assign res.notify_request    = nreq;
  assign res.notify_queue      = nq;

endmodule

// ----- hw/rtl/virtio_balloon_mmio_registers.sv -----
// Top level of the balloon virtio-mmio register block.
//
// One bus access per slave-side transfer: tuser carries the access kind
// (0 read, 1 write), tdata the byte offset, write data and current time.
// Each access returns one master-side transfer with read data, the pending
// interrupt bits after the access, a config-interrupt flag and a notify
// request with its queue number.
// An accepted transfer waits in the input register while decode and the
// 64-bit deadline compare and add run, then moves into the result register
// that drives m_tdata. Throughput is one access per cycle while the receiver
// takes results; the state is updated as an access moves into the result
// register, so the next access sees it.
// When the receiver stalls, the result register holds and the input register
// still takes one more access; s_tready drops only when both are full.
// The config port (cfg_we, cfg_index, cfg_wdata) writes page_goal (0) and
// retarget_period (1); write it only while no access is in flight.
// Synchronous reset clears all device state, empties both registers and puts
// the config registers back to 1024 pages and 0x08000000 ticks.
module virtio_balloon_mmio_registers (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // [8:0] byte_offset, [40:9] write_data, [104:41] time_now, rest zero
  input  logic [vbmmio_pkg::IN_TDATA_W-1:0]    s_tdata,
  // [0] action
  input  logic [vbmmio_pkg::IN_TUSER_W-1:0]    s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [31:0] read_data, [33:32] interrupt_status, [34] config_irq_raised,
  // [35] notify_request, [36] notify_queue, rest zero
  output logic [vbmmio_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input  logic                                 cfg_we,
  input  logic [vbmmio_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vbmmio_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import vbmmio_pkg::*;

  logic        in_valid;
  item_t       in_item;
  logic        out_valid;
  res_t        out_res;
  res_t        res;
  logic        advance;
  logic        fire;
  logic [31:0] page_goal;
  logic [31:0] retarget_period;

  assign advance  = !out_valid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) in_valid <= s_tvalid;
      if (advance) out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.action      <= s_tuser[0];
      in_item.byte_offset <= s_tdata[8:0];
      in_item.write_data  <= s_tdata[40:9];
      in_item.time_now    <= s_tdata[104:41];
    end
    if (fire) out_res <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page_goal       <= PAGE_GOAL_RST;
      retarget_period <= RETARGET_PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PAGE_GOAL:       page_goal       <= cfg_wdata;
        CFG_RETARGET_PERIOD: retarget_period <= cfg_wdata;
        default: ;
      endcase
    end
  end

  vbmmio_regs u_regs (
    .clk             (clk),
    .rst             (rst),
    .fire            (fire),
    .item            (in_item),
    .page_goal       (page_goal),
    .retarget_period (retarget_period),
    .res             (res)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_res};

endmodule

// ----- hw/rtl/vbmmio_checker.sv -----
// Port-level checks of the balloon register block, bound to the top level.
module vbmmio_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [vbmmio_pkg::OUT_TDATA_W-1:0]  m_tdata
);
  import vbmmio_pkg::*;

  // nothing comes out in the cycle after a reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // a retarget always leaves the config interrupt pending
  a_irq_pending: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[34] |-> m_tdata[33])
    else $error("config interrupt raised but not pending");

  // a queue number only comes with a notify request, which never raises on reads
  a_notify_q: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[36] |-> m_tdata[35])
    else $error("notify queue set without request");

  // an empty block with a free output takes input
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid && $past(!s_tvalid) && !$past(rst) |-> s_tready)
    else $error("input stalled while block empty");

endmodule

bind virtio_balloon_mmio_registers vbmmio_checker u_vbmmio_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- tb/tb_virtio_balloon_mmio_registers.sv -----
// Self-checking stream testbench for the balloon virtio-mmio register block.
module tb_virtio_balloon_mmio_registers;
  timeunit 1ns;
  timeprecision 1ps;
  import vbmmio_pkg::*;

  localparam int RES_W            = OUT_TDATA_W - OUT_PAD_W;
  localparam int N_DIRECTED       = 28;
  localparam int N_BRINGUP        = 11;
  localparam int N_PHASES         = 5;
  localparam int PHASE_ITEMS      = 214;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int DRAIN_SLACK      = 8;

  // Offsets outside the package map
  localparam logic [8:0] OFF_UNALIGNED  = 9'h002;
  localparam logic [8:0] OFF_DRV_FEAT   = 9'h020;
  localparam logic [8:0] OFF_QUEUE_NUM  = 9'h038;
  localparam logic [8:0] OFF_WINDOW_TOP = 9'h1FF;

  // Device status bits
  localparam logic [31:0] DS_ACK         = 32'h1;
  localparam logic [31:0] DS_DRIVER      = 32'h2;
  localparam logic [31:0] DS_DRIVER_OK   = 32'h4;
  localparam logic [31:0] DS_FEATURES_OK = 32'h8;
  localparam logic [31:0] DS_RESET       = 32'h0;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  typedef struct {
    logic        act;
    logic [8:0]  off;
    logic [31:0] wd;
    logic [63:0] tn;
    bit          typed;
    logic [31:0] want_rd;
  } access_row_t;

  // Shadow of the device state and config
  logic [31:0] sh_goal, sh_period;
  logic [31:0] sh_status, sh_feat_sel, sh_qsel, sh_target, sh_actual, sh_gen;
  logic [1:0]  sh_irq;
  logic        sh_qready [2];
  logic [63:0] sh_deadline;

  res_t        access_results_due [$];
  logic [63:0] bus_time = 64'd0;
  int          src_calm = 0;
  bit          sink_long_hold = 1'b0;
  int          err_count = 0;
  int          n_accesses = 0;
  int          n_checked = 0;
  int          n_flips = 0;
  int          n_notifies = 0;
  int          in_stall_cycles = 0;

  logic [31:0] phase_goal [N_PHASES];
  logic [31:0] phase_period [N_PHASES];

  logic [8:0] offs_pool [18] = '{
    OFF_MAGIC, OFF_VERSION, OFF_DEVICE_ID, OFF_VENDOR_ID, OFF_DEV_FEAT, OFF_DEV_FEAT_SEL,
    OFF_QUEUE_SEL, OFF_QUEUE_NUM_MAX, OFF_QUEUE_READY, OFF_QUEUE_NOTIFY, OFF_INT_STATUS,
    OFF_INT_ACK, OFF_STATUS, OFF_CFG_GEN, OFF_NUM_PAGES, OFF_ACTUAL, OFF_DRV_FEAT,
    OFF_QUEUE_NUM
  };

  access_row_t directed_rows [N_DIRECTED] = '{
    '{ACT_READ,  OFF_MAGIC,         32'h0,         64'd0, 1'b1, ID_MAGIC},
    '{ACT_READ,  OFF_VERSION,       32'hFFFF_FFFF, 64'd0, 1'b1, ID_VERSION},
    '{ACT_READ,  OFF_DEVICE_ID,     32'h0,         64'd0, 1'b1, ID_DEVICE},
    '{ACT_READ,  OFF_VENDOR_ID,     32'h0,         64'd0, 1'b1, ID_VENDOR},
    '{ACT_READ,  OFF_WINDOW_TOP,    32'h0,         64'd0, 1'b1, 32'd0},
    '{ACT_READ,  OFF_UNALIGNED,     32'h0,         64'd0, 1'b1, 32'd0},
    '{ACT_WRITE, OFF_DEV_FEAT_SEL,  32'd1,         64'd0, 1'b0, 32'd0},
    '{ACT_READ,  OFF_DEV_FEAT,      32'h0,         64'd0, 1'b0, 32'd0},
    '{ACT_WRITE, OFF_QUEUE_SEL,     32'hFFFF_FFFF, 64'd0, 1'b0, 32'd0},
    '{ACT_READ,  OFF_QUEUE_NUM_MAX, 32'h0,         64'd0, 1'b1, 32'd0},
    '{ACT_WRITE, OFF_QUEUE_READY,   32'hFFFF_FFFF, 64'd0, 1'b0, 32'd0},
    '{ACT_READ,  OFF_QUEUE_READY,   32'h0,         64'd0, 1'b0, 32'd0},
    // notifies before driver-OK: requests only, timer idle
    '{ACT_WRITE, OFF_QUEUE_NOTIFY,  32'd0,         64'd0, 1'b0, 32'd0},
    '{ACT_WRITE, OFF_QUEUE_NOTIFY,  32'd1,         64'd0, 1'b0, 32'd0},
    '{ACT_WRITE, OFF_QUEUE_NOTIFY,  32'hFFFF_FFFF, 64'd0, 1'b0, 32'd0},
    '{ACT_WRITE, OFF_STATUS,        DS_ACK,        64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'd0},
    '{ACT_WRITE, OFF_STATUS,        32'hFFFF_FFFF, 64'd0, 1'b0, 32'd0},
    '{ACT_WRITE, OFF_QUEUE_NOTIFY,  32'd1,         64'd5, 1'b0, 32'd0},
    // deadline lands exactly on 2^64 and wraps to "none"
    '{ACT_WRITE, OFF_INT_ACK,       32'd3,  64'hFFFF_FFFF_F800_0000, 1'b0, 32'd0},
    '{ACT_WRITE, OFF_QUEUE_NOTIFY,  32'd0,         64'd1, 1'b0, 32'd0},
    '{ACT_READ,  OFF_NUM_PAGES,     32'h0,         64'd2, 1'b0, 32'd0},
    '{ACT_WRITE, OFF_NUM_PAGES,     32'hFFFF_FFFF, 64'd2, 1'b0, 32'd0},
    '{ACT_WRITE, OFF_ACTUAL,        32'hFFFF_FFFF, 64'd2, 1'b0, 32'd0},
    '{ACT_READ,  OFF_ACTUAL,        32'h0,         64'd2, 1'b0, 32'd0},
    '{ACT_WRITE, OFF_DRV_FEAT,      32'hFFFF_FFFF, 64'd2, 1'b0, 32'd0},
    '{ACT_READ,  OFF_CFG_GEN,       32'h0,         64'd2, 1'b0, 32'd0},
    '{ACT_WRITE, OFF_STATUS,        DS_RESET,      64'd3, 1'b0, 32'd0},
    '{ACT_READ,  OFF_STATUS,        32'h0,         64'd3, 1'b0, 32'd0}
  };

  // Usual driver init: reset, negotiate, enable both queues, driver-OK
  access_row_t bringup_rows [N_BRINGUP] = '{
    '{ACT_WRITE, OFF_STATUS,       DS_RESET,       64'd0, 1'b0, 32'd0},
    '{ACT_WRITE, OFF_STATUS,       DS_ACK,         64'd0, 1'b0, 32'd0},
    '{ACT_WRITE, OFF_STATUS,       DS_ACK | DS_DRIVER, 64'd0, 1'b0, 32'd0},
    '{ACT_WRITE, OFF_DEV_FEAT_SEL, 32'd1,          64'd0, 1'b0, 32'd0},
    '{ACT_READ,  OFF_DEV_FEAT,     32'd0,          64'd0, 1'b0, 32'd0},
    '{ACT_WRITE, OFF_STATUS, DS_ACK | DS_DRIVER | DS_FEATURES_OK, 64'd0, 1'b0, 32'd0},
    '{ACT_WRITE, OFF_QUEUE_SEL,    32'd0,          64'd0, 1'b0, 32'd0},
    '{ACT_WRITE, OFF_QUEUE_READY,  32'd1,          64'd0, 1'b0, 32'd0},
    '{ACT_WRITE, OFF_QUEUE_SEL,    32'd1,          64'd0, 1'b0, 32'd0},
    '{ACT_WRITE, OFF_QUEUE_READY,  32'd1,          64'd0, 1'b0, 32'd0},
    '{ACT_WRITE, OFF_STATUS,
      DS_ACK | DS_DRIVER | DS_FEATURES_OK | DS_DRIVER_OK, 64'd0, 1'b0, 32'd0}
  };

  always #5 clk = ~clk;

  virtio_balloon_mmio_registers dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
  endfunction

  function automatic bit retarget_tick(logic [63:0] now);
    if (!sh_status[STATUS_DRV_OK_BIT]) return 1'b0;
    if (sh_deadline != 64'd0 && now < sh_deadline) return 1'b0;
    sh_deadline = now + {32'd0, sh_period};
    sh_target   = (sh_target == 32'd0) ? sh_goal : 32'd0;
    sh_gen      = sh_gen + 32'd1;
    sh_irq      = sh_irq | IRQ_CONFIG;
    return 1'b1;
  endfunction

  function automatic res_t predict_access(item_t a);
    res_t r;
    r = '0;
    if (a.action == ACT_READ) begin
      case (a.byte_offset)
        OFF_MAGIC:         r.read_data = ID_MAGIC;
        OFF_VERSION:       r.read_data = ID_VERSION;
        OFF_DEVICE_ID:     r.read_data = ID_DEVICE;
        OFF_VENDOR_ID:     r.read_data = ID_VENDOR;
        OFF_DEV_FEAT:      r.read_data = (sh_feat_sel == 32'd1) ? 32'd1 : 32'd0;
        OFF_QUEUE_NUM_MAX: r.read_data = (sh_qsel < 32'd2) ? QSIZE_MAX : 32'd0;
        OFF_QUEUE_READY:   r.read_data = {31'd0, sh_qready[sh_qsel[0]]};
        OFF_INT_STATUS:    r.read_data = {30'd0, sh_irq};
        OFF_STATUS:        r.read_data = sh_status;
        OFF_CFG_GEN:       r.read_data = sh_gen;
        OFF_NUM_PAGES:     r.read_data = sh_target;
        OFF_ACTUAL:        r.read_data = sh_actual;
        default:           r.read_data = 32'd0;
      endcase
    end else begin
      case (a.byte_offset)
        OFF_DEV_FEAT_SEL: sh_feat_sel = a.write_data;
        OFF_QUEUE_SEL:    sh_qsel = a.write_data;
        OFF_QUEUE_READY:  sh_qready[sh_qsel[0]] = a.write_data[0];
        OFF_QUEUE_NOTIFY: begin
          r.config_irq_raised = retarget_tick(a.time_now);
          if (a.write_data <= 32'd1) begin
            r.notify_request = 1'b1;
            r.notify_queue   = a.write_data[0];
          end
        end
        OFF_INT_ACK: begin
          sh_irq = sh_irq & ~a.write_data[1:0];
          r.config_irq_raised = retarget_tick(a.time_now);
        end
        OFF_ACTUAL: sh_actual = a.write_data;
        OFF_STATUS: begin
          sh_status = a.write_data;
          if (a.write_data == DS_RESET) begin
            sh_irq       = 2'b00;
            sh_target    = 32'd0;
            sh_actual    = 32'd0;
            sh_gen       = 32'd0;
            sh_deadline  = 64'd0;
            sh_qready[0] = 1'b0;
            sh_qready[1] = 1'b0;
          end else begin
            r.config_irq_raised = retarget_tick(a.time_now);
          end
        end
        default: ;
      endcase
    end
    r.interrupt_status = sh_irq;
    return r;
  endfunction

  function automatic item_t rand_access();
    item_t a;
    int    pick;
    // time mostly creeps forward, often in steps near the period, so the timer fires
    case ($urandom_range(0, 9))
      0, 1, 2, 3: bus_time = bus_time + 64'($urandom_range(0, 8));
      4, 5, 6:    bus_time = bus_time + {32'd0, sh_period} - 64'd1 + 64'($urandom_range(0, 2));
      7:          bus_time = bus_time + {$urandom, $urandom} % ({32'd0, sh_period} * 64'd3 + 64'd1);
      8:          bus_time = {$urandom, $urandom};
      default:    bus_time = 64'd0 - {32'd0, sh_period} - 64'($urandom_range(0, 2));
    endcase
    a.time_now   = bus_time;
    a.write_data = $urandom;
    a.action     = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 15);
    if (pick == 0) begin
      a.byte_offset = 9'($urandom_range(0, 511));
    end else if (pick <= 4) begin
      a.action      = ACT_WRITE;
      a.byte_offset = (pick <= 2) ? OFF_QUEUE_NOTIFY : OFF_INT_ACK;
    end else begin
      a.byte_offset = offs_pool[$urandom_range(0, 17)];
    end
    if (a.action == ACT_WRITE && $urandom_range(0, 7) != 0) begin
      case (a.byte_offset)
        OFF_STATUS:
          a.write_data = ($urandom_range(0, 7) == 0) ? DS_RESET
                                                     : (DS_DRIVER_OK | $urandom_range(0, 15));
        OFF_QUEUE_NOTIFY, OFF_QUEUE_READY: a.write_data = $urandom_range(0, 1);
        OFF_INT_ACK, OFF_QUEUE_SEL:        a.write_data = $urandom_range(0, 3);
        OFF_DEV_FEAT_SEL:                  a.write_data = $urandom_range(0, 2);
        default: ;
      endcase
    end
    return a;
  endfunction

  // Offer one access, wait for the transfer, then log its expected result
  task automatic send_access(item_t a, bit typed, logic [31:0] typed_rd);
    res_t pred;
    res_t fixed;
    if (src_calm > 0) begin
      src_calm--;
    end else if ($urandom_range(0, 19) == 0) begin
      src_calm = $urandom_range(20, 60);
    end else if ($urandom_range(0, 2) == 0) begin
      s_tvalid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TDATA_W - 105){1'b0}}, a.time_now, a.write_data, a.byte_offset};
    s_tuser  <= a.action;
    do @(posedge clk); while (!s_tready);
    pred = predict_access(a);
    fixed = '0;
    fixed.read_data = typed_rd;
    access_results_due.push_back(typed ? fixed : pred);
    n_accesses++;
  endtask

  function automatic item_t row_item(access_row_t row, logic [63:0] tn);
    item_t a;
    a.action      = row.act;
    a.byte_offset = row.off;
    a.write_data  = row.wd;
    a.time_now    = tn;
    return a;
  endfunction

  task automatic wait_results_done();
    s_tvalid <= 1'b0;
    wait (access_results_due.size() == 0);
    @(posedge clk);
  endtask

  task automatic set_balloon_cfg(logic [31:0] goal, logic [31:0] period);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PAGE_GOAL;
    cfg_wdata <= goal;
    @(posedge clk);
    cfg_index <= CFG_RETARGET_PERIOD;
    cfg_wdata <= period;
    @(posedge clk);
    cfg_we  <= 1'b0;
    sh_goal   = goal;
    sh_period = period;
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_count++;
    end
  endtask

  // Result side: random ready, with one long hold on request
  initial begin : result_sink
    int left;
    left = 0;
    forever begin
      @(posedge clk);
      if (sink_long_hold) begin
        sink_long_hold = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        m_tready <= 1'b1;
        left = $urandom_range(1, 6);
      end else if (left > 0) begin
        left--;
      end else if (m_tready) begin
        m_tready <= 1'b0;
        left = gap_len() - 1;
      end else begin
        m_tready <= 1'b1;
        left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      end
    end
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst) begin
      if (s_tvalid && !s_tready) in_stall_cycles++;
      if (m_tvalid && m_tready) begin
        got = res_t'(m_tdata[RES_W-1:0]);
        if (access_results_due.size() == 0) begin
          $error("result transfer with no access outstanding: 0x%0h", m_tdata);
          err_count++;
        end else begin
          want = access_results_due.pop_front();
          check_field("read_data", 64'(want.read_data), 64'(got.read_data));
          check_field("interrupt_status", 64'(want.interrupt_status),
                      64'(got.interrupt_status));
          check_field("config_irq_raised", 64'(want.config_irq_raised),
                      64'(got.config_irq_raised));
          check_field("notify_request", 64'(want.notify_request), 64'(got.notify_request));
          check_field("notify_queue", 64'(want.notify_queue), 64'(got.notify_queue));
          check_field("tdata padding", 64'd0, 64'(m_tdata[OUT_TDATA_W-1:RES_W]));
          n_checked++;
          if (want.config_irq_raised) n_flips++;
          if (want.notify_request) n_notifies++;
        end
      end
    end
  end

  initial begin : run_limit
    #5ms;
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    sh_goal      = PAGE_GOAL_RST;
    sh_period    = RETARGET_PERIOD_RST;
    sh_status    = 32'd0;
    sh_feat_sel  = 32'd0;
    sh_qsel      = 32'd0;
    sh_target    = 32'd0;
    sh_actual    = 32'd0;
    sh_gen       = 32'd0;
    sh_irq       = 2'b00;
    sh_qready[0] = 1'b0;
    sh_qready[1] = 1'b0;
    sh_deadline  = 64'd0;

    phase_goal[0] = 32'hFFFF_FFFF;     phase_period[0] = 32'd1;
    phase_goal[1] = 32'd0;             phase_period[1] = 32'hFFFF_FFFF;
    phase_goal[2] = $urandom;          phase_period[2] = $urandom_range(1, 200);
    phase_goal[3] = PAGE_GOAL_RST;     phase_period[3] = RETARGET_PERIOD_RST;
    phase_goal[4] = $urandom;          phase_period[4] = $urandom_range(1, 32'hFFFF_FFFF);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed accesses run on the reset-time config
    foreach (directed_rows[k]) begin
      send_access(row_item(directed_rows[k], directed_rows[k].tn),
                  directed_rows[k].typed, directed_rows[k].want_rd);
    end
    wait_results_done();

    for (int p = 0; p < N_PHASES; p++) begin
      set_balloon_cfg(phase_goal[p], phase_period[p]);
      foreach (bringup_rows[k]) begin
        send_access(row_item(bringup_rows[k], bus_time), 1'b0, 32'd0);
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 1 && i == 100) sink_long_hold = 1'b1;
        if (p == 2 && i == 120) wait_results_done();
        send_access(rand_access(), 1'b0, 32'd0);
      end
      wait_results_done();
    end

    repeat (DRAIN_SLACK) @(posedge clk);
    $display("tb: %0d accesses over %0d config settings, %0d results checked",
             n_accesses, N_PHASES + 1, n_checked);
    $display("tb: %0d target flips, %0d notify requests, %0d cycles of input backpressure",
             n_flips, n_notifies, in_stall_cycles);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
